// ===== hw/rtl/dlxsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual LCG XOR stream cipher package
// Shared widths, reset values, register indexes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package dlxsc_pkg;

    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] MULT_FIRST_RST  = 32'd184038653;
    localparam logic [WORD_W-1:0] INCR_FIRST_RST  = 32'd103701121;
    localparam logic [WORD_W-1:0] MULT_SECOND_RST = 32'd194625377;
    localparam logic [WORD_W-1:0] INCR_SECOND_RST = 32'd203465495;
    localparam logic [WORD_W-1:0] SEED_RST        = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT_FIRST  = 3'd0,
        CFG_INCR_FIRST  = 3'd1,
        CFG_MULT_SECOND = 3'd2,
        CFG_INCR_SECOND = 3'd3,
        CFG_SEED_FIRST  = 3'd4,
        CFG_SEED_SECOND = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] mult_first;
        logic [WORD_W-1:0] incr_first;
        logic [WORD_W-1:0] mult_second;
        logic [WORD_W-1:0] incr_second;
        logic [WORD_W-1:0] seed_first;
        logic [WORD_W-1:0] seed_second;
    } cfg_regs_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              func;
        logic              restart;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [WORD_W-1:0] check_value;
    } out_item_t;

    // Which word of a transaction the checksum covers.
    typedef enum logic [0:0] {
        SUM_FROM_OUTPUT = 1'b0,
        SUM_FROM_INPUT  = 1'b1
    } sum_src_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic              reload;
        sum_src_t          sum_src;
        logic [WORD_W-1:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dlxsc_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the generator multipliers, increments and seeds.
// ----------------------------------------------------------------------------
`default_nettype none

module dlxsc_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dlxsc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [dlxsc_pkg::WORD_W-1:0]    cfg_wr_data,
    output dlxsc_pkg::cfg_regs_t                cfg
);
    import dlxsc_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_MULT_FIRST:  cfg_next.mult_first  = cfg_wr_data;
                CFG_INCR_FIRST:  cfg_next.incr_first  = cfg_wr_data;
                CFG_MULT_SECOND: cfg_next.mult_second = cfg_wr_data;
                CFG_INCR_SECOND: cfg_next.incr_second = cfg_wr_data;
                CFG_SEED_FIRST:  cfg_next.seed_first  = cfg_wr_data;
                CFG_SEED_SECOND: cfg_next.seed_second = cfg_wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mult_first  <= MULT_FIRST_RST;
            cfg_reg.incr_first  <= INCR_FIRST_RST;
            cfg_reg.mult_second <= MULT_SECOND_RST;
            cfg_reg.incr_second <= INCR_SECOND_RST;
            cfg_reg.seed_first  <= SEED_RST;
            cfg_reg.seed_second <= SEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dlxsc_front.sv =====
// ----------------------------------------------------------------------------
// Front part
// Accepts input transactions, classifies them and queues the commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dlxsc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dlxsc_pkg::in_item_t s_data,
    output logic                     q_valid,
    output dlxsc_pkg::cmd_t          q_cmd,
    input  wire logic                q_pop
);
    import dlxsc_pkg::*;

    cmd_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    cmd_t                   new_cmd;

    always_comb begin
        new_cmd.reload  = s_data.restart;
        new_cmd.sum_src = s_data.func ? SUM_FROM_INPUT : SUM_FROM_OUTPUT;
        new_cmd.data    = s_data.data_word;
    end

    assign s_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dlxsc_back.sv =====
// ----------------------------------------------------------------------------
// Back part
// Steps both generators, applies the keystream and keeps the checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module dlxsc_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dlxsc_pkg::cfg_regs_t cfg,
    input  wire logic                 q_valid,
    input  wire dlxsc_pkg::cmd_t      q_cmd,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output dlxsc_pkg::out_item_t      m_data
);
    import dlxsc_pkg::*;

    logic [WORD_W-1:0] gen_first_reg;
    logic [WORD_W-1:0] gen_first_next;
    logic [WORD_W-1:0] gen_second_reg;
    logic [WORD_W-1:0] gen_second_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic              out_valid_reg;
    out_item_t         out_reg;
    out_item_t         out_next;
    logic [WORD_W-1:0] base_first;
    logic [WORD_W-1:0] base_second;
    logic [WORD_W-1:0] base_sum;
    logic [WORD_W-1:0] key_word;

    // The output register is free when empty or being drained this cycle.
    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    always_comb begin
        base_first      = q_cmd.reload ? cfg.seed_first  : gen_first_reg;
        base_second     = q_cmd.reload ? cfg.seed_second : gen_second_reg;
        base_sum        = q_cmd.reload ? '0 : sum_reg;
        gen_first_next  = base_first  * cfg.mult_first  + cfg.incr_first;
        gen_second_next = base_second * cfg.mult_second + cfg.incr_second;
        key_word        = gen_first_next ^ gen_second_next;
        out_next.out_word = q_cmd.data ^ key_word;
        if (q_cmd.sum_src == SUM_FROM_INPUT) begin
            sum_next = base_sum ^ q_cmd.data;
        end else begin
            sum_next = base_sum ^ out_next.out_word;
        end
        out_next.check_value = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_first_reg  <= '0;
            gen_second_reg <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                gen_first_reg  <= gen_first_next;
                gen_second_reg <= gen_second_next;
                sum_reg        <= sum_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dual_lcg_xor_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// Dual LCG XOR stream cipher, top level
// Word-wide stream cipher built from two linear congruential generators.
// ----------------------------------------------------------------------------
// The block takes one 32-bit word per clock cycle unless back-pressured and
// returns one result per transaction. Each transaction steps both generators
// once (state * mult + incr, modulo 2^32), XORs the two new states into a
// keystream word and XORs that into the data word. The sustained rate of one
// transaction per cycle, with no output stall, is set by the combinational
// multiply-add of each generator in the back part, whose state feeds straight
// back into its own multiplier. A set restart bit loads both generators from
// the seed registers and clears the checksum before the word is used; until
// the first restart after reset the generators run from zero. The checksum is
// the running XOR of the plaintext: the input word when func is 1 (encode),
// the output word when func is 0 (decode). A two-entry command queue separates
// the input channel from the back part, and the output register lets a new
// transaction in while a result waits. The user must write the configuration
// registers (index 0 to 5: mult_first, incr_first, mult_second, incr_second,
// seed_first, seed_second) only while the block is idle; the block does not
// enforce this. Writes to other indexes are ignored.
`default_nettype none

module dual_lcg_xor_stream_cipher_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire dlxsc_pkg::in_item_t             s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output dlxsc_pkg::out_item_t                 m_data,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dlxsc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [dlxsc_pkg::WORD_W-1:0]    cfg_wr_data
);
    import dlxsc_pkg::*;

    // Register file contents, read directly by the back part.
    cfg_regs_t cfg;

    // Command queue handoff between front and back.
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    dlxsc_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // The front part classifies each transaction into a command and queues it.
    dlxsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // The back part holds the generator and checksum state and the result.
    dlxsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dlxsc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports for occupancy, latency and checksum behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module dlxsc_port_checker (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire dlxsc_pkg::in_item_t  s_data,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire dlxsc_pkg::out_item_t m_data
);
    import dlxsc_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 3'd1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Queue plus output register never hold more than three transactions.
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg <= 3'd3 && (!m_valid || inflight_reg != 3'd0)))
        else $error("result shown with nothing in flight or too many in flight");

    // Input back-pressure only appears once the queue is full.
    a_ready_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> inflight_reg >= 3'd2)
        else $error("input stalled while the block has room");

    // An idle block shows a fresh result once the command has passed the queue and the output register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && inflight_reg == 3'd0) |-> ##2 m_valid)
        else $error("result missing two cycles after an idle acceptance");

    // An encoding restart word starts the checksum over with that word.
    a_restart_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && inflight_reg == 3'd0 && s_data.restart && s_data.func)
        |-> ##2 (m_data.check_value == $past(s_data.data_word, 2)))
        else $error("checksum not restarted from the encoded word");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind dual_lcg_xor_stream_cipher_top dlxsc_port_checker u_port_checker (.*);

`default_nettype wire

// ===== tb/dlxsc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual LCG XOR stream cipher checker
// Watches both channels and the register port. It predicts each result from
// its own copy of the generators and checksum, and compares the results in
// order.
// ----------------------------------------------------------------------------

module dlxsc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  dlxsc_pkg::in_item_t             s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  dlxsc_pkg::out_item_t            m_data,
    input  logic                            cfg_wr_en,
    input  logic [dlxsc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [dlxsc_pkg::WORD_W-1:0]    cfg_wr_data,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked
);
    import dlxsc_pkg::*;

    localparam int MAX_REPORTS = 40;

    // Shadow copy of the register file.
    logic [WORD_W-1:0] mul_a, inc_a, mul_b, inc_b, seed_a, seed_b;
    // Shadow copy of the generator states and the plaintext checksum.
    logic [WORD_W-1:0] lcg_a, lcg_b, plain_sum;

    out_item_t expected_results[$];
    int errors = 0;
    int compared = 0;

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
    end

    task automatic report_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Steps both generators once and returns the enciphered word and checksum.
    function automatic out_item_t predict_cipher(input in_item_t item);
        out_item_t res;
        if (item.restart) begin
            lcg_a     = seed_a;
            lcg_b     = seed_b;
            plain_sum = '0;
        end
        lcg_a = lcg_a * mul_a + inc_a;
        lcg_b = lcg_b * mul_b + inc_b;
        res.out_word = item.data_word ^ lcg_a ^ lcg_b;
        if (sum_src_t'(item.func) == SUM_FROM_INPUT) begin
            plain_sum ^= item.data_word;
        end else begin
            plain_sum ^= res.out_word;
        end
        res.check_value = plain_sum;
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            mul_a     = MULT_FIRST_RST;
            inc_a     = INCR_FIRST_RST;
            mul_b     = MULT_SECOND_RST;
            inc_b     = INCR_SECOND_RST;
            seed_a    = SEED_RST;
            seed_b    = SEED_RST;
            lcg_a     = '0;
            lcg_b     = '0;
            plain_sum = '0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_MULT_FIRST:  mul_a  = cfg_wr_data;
                    CFG_INCR_FIRST:  inc_a  = cfg_wr_data;
                    CFG_MULT_SECOND: mul_b  = cfg_wr_data;
                    CFG_INCR_SECOND: inc_b  = cfg_wr_data;
                    CFG_SEED_FIRST:  seed_a = cfg_wr_data;
                    CFG_SEED_SECOND: seed_b = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_cipher(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_failure($sformatf("result %h/%h arrived with nothing expected",
                                             m_data.out_word, m_data.check_value));
                end else begin
                    want = expected_results.pop_front();
                    compared++;
                    if (m_data.out_word !== want.out_word) begin
                        report_failure($sformatf("out_word of result %0d: got %h, expected %h",
                                                 compared, m_data.out_word, want.out_word));
                    end
                    if (m_data.check_value !== want.check_value) begin
                        report_failure($sformatf("check_value of result %0d: got %h, expected %h",
                                                 compared, m_data.check_value,
                                                 want.check_value));
                    end
                end
            end
        end
        fail_count      <= errors;
        pending         <= expected_results.size();
        results_checked <= compared;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual LCG XOR stream cipher testbench
// Drives directed and random word streams through the cipher under several
// register settings, with random stalls on both channels, and reports a
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------

module testbench;
    import dlxsc_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PERCENT    = 35;
    // Margin after the last result, so that the block is quiet before the registers change.
    localparam int DRAIN_CYCLES    = 8;
    // Far above what the slowest correct run needs with both sides stalling.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 148;

    // Indexes past the last register. Writes to them must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    in_item_t             s_data       = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [WORD_W-1:0]    cfg_wr_data  = '0;

    // When low, neither side inserts idle cycles.
    logic idling_on = 1'b1;

    int cycle_count   = 0;
    int words_sent    = 0;
    int restarts_sent = 0;
    int encodes_sent  = 0;
    int settings_used = 1;
    int fail_count;
    int pending;
    int results_checked;

    dual_lcg_xor_stream_cipher_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    dlxsc_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // 12 ns clock period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog. A hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The result side stalls in about a third of the cycles, except during the
    // stretch where idling is switched off.
    always @(posedge aclk) begin
        m_ready <= !idling_on || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Data words lean toward the corners now and then: all zeros, all ones and
    // a single set bit. Everything else is uniformly random.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << $urandom_range(WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic sum_src_t rand_src();
        return sum_src_t'($urandom_range(1));
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // Valid stays high straight into the next transaction unless an idle gap
    // is drawn, so back-to-back transfers happen as well.
    task automatic send_word(input logic [WORD_W-1:0] word, input sum_src_t src,
                             input logic restart);
        in_item_t item;
        item.data_word = word;
        item.func      = src;
        item.restart   = restart;
        if (idling_on) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (restart) restarts_sent++;
        if (src == SUM_FROM_INPUT) encodes_sent++;
    endtask

    // Register writes leave the enable high between back-to-back writes; the
    // caller drops it with cfg_close once the burst is done.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
                             input logic [WORD_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    task automatic cfg_close();
        cfg_wr_en <= 1'b0;
    endtask

    // Writes all six registers, then pokes both unused indexes with random
    // data. The checker ignores those, so any effect on the block shows up as
    // a mismatch.
    task automatic load_regs(input logic [WORD_W-1:0] m1, input logic [WORD_W-1:0] i1,
                             input logic [WORD_W-1:0] m2, input logic [WORD_W-1:0] i2,
                             input logic [WORD_W-1:0] s1, input logic [WORD_W-1:0] s2);
        cfg_write(CFG_MULT_FIRST, m1);
        cfg_write(CFG_INCR_FIRST, i1);
        cfg_write(CFG_MULT_SECOND, m2);
        cfg_write(CFG_INCR_SECOND, i2);
        cfg_write(CFG_SEED_FIRST, s1);
        cfg_write(CFG_SEED_SECOND, s2);
        cfg_write(CFG_IDX_SPARE_LO, $urandom);
        cfg_write(CFG_IDX_SPARE_HI, $urandom);
        cfg_close();
        settings_used++;
    endtask

    // Drops valid and waits until every expected result has come back, plus a
    // short margin. The first edge lets the checker's count catch up with the
    // transaction accepted at the current edge.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One random phase. It opens with a few words that do not restart, so a
    // seed written just before is not yet in effect. After that it is mostly
    // well-formed messages (a restart followed by words in one direction)
    // with some stray words of random direction and restart mixed in.
    task automatic run_phase(input int count);
        int       sent;
        int       run_len;
        sum_src_t src;
        sent = 0;
        repeat (3) begin
            send_word(rand_word(), rand_src(), 1'b0);
            sent++;
        end
        while (sent < count) begin
            if ($urandom_range(9) < 8) begin
                run_len = $urandom_range(24, 1);
                src     = rand_src();
                for (int k = 0; k < run_len && sent < count; k++) begin
                    send_word(rand_word(), src, k == 0);
                    sent++;
                end
            end else begin
                send_word(rand_word(), rand_src(), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Register settings for the random phases, the extremes among them.
    task automatic program_setting(input int setting);
        case (setting)
            // Everything zero: the generators stick at zero, so the keystream
            // is zero and the data passes through unchanged.
            0: load_regs('0, '0, '0, '0, '0, '0);
            // Everything at all ones.
            1: load_regs('1, '1, '1, '1, '1, '1);
            // Fully random.
            2: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            // First generator frozen at its seed, second one random.
            3: load_regs(32'd1, '0, $urandom, $urandom, $urandom, $urandom);
            // Multiplier of minus one with a unit increment, edge-case seeds.
            4: load_regs('1, 32'd1, '1, 32'd1, 32'h8000_0000, 32'h0000_0001);
            // Random again, with odd multipliers and increments.
            5: load_regs($urandom | 32'd1, $urandom | 32'd1, $urandom | 32'd1,
                         $urandom | 32'd1, $urandom, $urandom);
            // Back to the reset constants, with random seeds.
            default: load_regs(MULT_FIRST_RST, INCR_FIRST_RST, MULT_SECOND_RST,
                               INCR_SECOND_RST, $urandom, $urandom);
        endcase
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings. The first words come before
        // any restart, so both generators run from zero rather than from the
        // seeds. The corners of the data word go through, two in each direction.
        send_word('0,           SUM_FROM_INPUT,  1'b0);
        send_word('1,           SUM_FROM_OUTPUT, 1'b0);
        send_word(32'h8000_0000, SUM_FROM_INPUT,  1'b0);
        send_word(32'h0000_0001, SUM_FROM_OUTPUT, 1'b0);
        // A restart reloads the reset seeds and clears the checksum.
        send_word(32'h5555_5555, SUM_FROM_INPUT,  1'b1);
        send_word(32'hAAAA_AAAA, SUM_FROM_INPUT,  1'b0);
        send_word('1,           SUM_FROM_OUTPUT, 1'b0);
        send_word('0,           SUM_FROM_OUTPUT, 1'b1);
        send_word(32'h7FFF_FFFF, SUM_FROM_INPUT,  1'b0);

        // New extreme settings. The seeds must stay out of play until the
        // next restart, and the arithmetic has to wrap at 32 bits.
        wait_idle();
        load_regs('1, '1, '1, '1, '1, '1);
        send_word('0,           SUM_FROM_INPUT,  1'b0);
        send_word(32'h1234_5678, SUM_FROM_OUTPUT, 1'b0);
        send_word('1,           SUM_FROM_OUTPUT, 1'b1);
        send_word(32'hFFFF_0000, SUM_FROM_INPUT,  1'b0);
        send_word(32'h0000_FFFF, SUM_FROM_INPUT,  1'b1);

        // Random phases, one register setting each. Phase 2 runs without any
        // idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            program_setting(p);
            idling_on <= (p != 2);
            run_phase(ITEMS_PER_PHASE);
        end

        wait_idle();
        $display("Sent %0d words (%0d restarts, %0d encode) over %0d register settings.",
                 words_sent, restarts_sent, encodes_sent, settings_used);
        $display("Compared %0d results for cipher word and checksum.", results_checked);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
